@@ src/header_checksum_deframer_core_assert.svh @@
// Assertion macros shared by the deframer RTL files.
`ifndef HEADER_CHECKSUM_DEFRAMER_CORE_ASSERT_SVH
`define HEADER_CHECKSUM_DEFRAMER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HCD_ASSERT_HOLDS(label, c, r, expr) \
  label: assert property (@(posedge c) disable iff (r) (expr)) \
    else $error("assertion failed");
`define HCD_ASSERT_IMPL(label, c, r, a, b) \
  label: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("assertion failed");
`define HCD_ASSERT_NEXT(label, c, r, a, b) \
  label: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define HCD_ASSERT_HOLDS(label, c, r, expr)
`define HCD_ASSERT_IMPL(label, c, r, a, b)
`define HCD_ASSERT_NEXT(label, c, r, a, b)
`endif
`endif

@@ src/hcd_pkg.sv @@
// Shared types, constants and helpers of the header checksum deframer.
`default_nettype none
package hcd_pkg;

  localparam int HDR_LEN = 6;
  localparam logic [2:0] CHECK_POS = 3'(HDR_LEN - 1);

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_CSUM    = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] channel;
    logic [7:0] data;
    logic       last;
  } result_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      n = n + {3'd0, v[b]};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

@@ src/header_checksum_deframer_core.sv @@
// Header checksum deframer: top level.
// Takes one link byte per transfer and splits the stream into messages with a
// 6-byte header (channel, 32-bit big-endian length, popcount check byte).
// Each payload byte comes out tagged with its channel, the final one with
// last set; a zero-length message gives one empty result and a bad check byte
// gives one error result, after which the next byte starts a new header.
// Header bytes other than the check byte give no result. One byte is taken
// every cycle while in_stall is low. A two-entry output stage (result register
// plus skid register) lets input keep flowing while a result waits; in_stall
// rises only when both entries are occupied.
`default_nettype none
module header_checksum_deframer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      result_kind,
  output logic [7:0]      channel,
  output logic [7:0]      payload_byte,
  output logic            last
);

  logic             accept;
  logic             push;
  logic             full;
  hcd_pkg::result_t res;
  hcd_pkg::result_t out_data;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  hcd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .push    (push),
    .res     (res)
  );

  hcd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign result_kind  = out_data.kind;
  assign channel      = out_data.channel;
  assign payload_byte = out_data.data;
  assign last         = out_data.last;

endmodule
`default_nettype wire

@@ src/hcd_parser.sv @@
// Header tracking, checksum compare and result formation for each byte.
`default_nettype none
`include "header_checksum_deframer_core_assert.svh"
module hcd_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       rx_byte,
  output logic                  push,
  output hcd_pkg::result_t      res
);

  logic [2:0]  header_position;
  logic [7:0]  message_channel;
  logic [31:0] length_shift;
  logic [5:0]  ones_count;
  logic [31:0] bytes_remaining;
  logic        in_payload;

  logic [31:0] remaining_next;
  logic [5:0]  pop_ext;
  logic        csum_ok;

  assign remaining_next = bytes_remaining - 32'd1;
  assign pop_ext        = {2'd0, hcd_pkg::pop8(rx_byte)};
  assign csum_ok        = (rx_byte == {2'd0, ones_count});

  always_comb begin
    push        = 1'b0;
    res.kind    = hcd_pkg::KIND_PAYLOAD;
    res.channel = message_channel;
    res.data    = 8'd0;
    res.last    = 1'b1;
    if (in_payload) begin
      push     = accept;
      res.data = rx_byte;
      res.last = (remaining_next == 32'd0);
    end else if (header_position >= hcd_pkg::CHECK_POS) begin
      if (!csum_ok) begin
        push     = accept;
        res.kind = hcd_pkg::KIND_CSUM;
      end else if (length_shift == 32'd0) begin
        push     = accept;
        res.kind = hcd_pkg::KIND_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= 3'd0;
      message_channel <= 8'd0;
      length_shift    <= 32'd0;
      ones_count      <= 6'd0;
      bytes_remaining <= 32'd0;
      in_payload      <= 1'b0;
    end else if (accept) begin
      if (in_payload) begin
        bytes_remaining <= remaining_next;
        if (remaining_next == 32'd0) begin
          in_payload <= 1'b0;
        end
      end else if (header_position == 3'd0) begin
        message_channel <= rx_byte;
        length_shift    <= 32'd0;
        ones_count      <= pop_ext;
        header_position <= 3'd1;
      end else if (header_position < hcd_pkg::CHECK_POS) begin
        length_shift    <= {length_shift[23:0], rx_byte};
        ones_count      <= ones_count + pop_ext;
        header_position <= header_position + 3'd1;
      end else begin
        // check byte: start the next header unless a payload follows
        header_position <= 3'd0;
        ones_count      <= 6'd0;
        if (csum_ok && length_shift != 32'd0) begin
          bytes_remaining <= length_shift;
          in_payload      <= 1'b1;
        end
      end
    end
  end

  `HCD_ASSERT_HOLDS(a_pos_range, clk, rst, header_position <= hcd_pkg::CHECK_POS)
  `HCD_ASSERT_IMPL(a_payload_count, clk, rst, in_payload, bytes_remaining != 32'd0)
  `HCD_ASSERT_IMPL(a_payload_pos, clk, rst, in_payload, header_position == 3'd0)
  `HCD_ASSERT_NEXT(a_last_leaves, clk, rst, accept && in_payload && res.last, !in_payload)

endmodule
`default_nettype wire

@@ src/hcd_out_buf.sv @@
// Output register with a skid stage on the result channel.
`default_nettype none
`include "header_checksum_deframer_core_assert.svh"
module hcd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire hcd_pkg::result_t  push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hcd_pkg::result_t       out_data
);

  logic             skid_valid;
  hcd_pkg::result_t skid_data;
  logic             advance;

  assign advance = !out_valid || !out_stall;
  assign full    = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (advance) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  `HCD_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `HCD_ASSERT_IMPL(a_no_push_when_full, clk, rst, skid_valid, !push)
  `HCD_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && !out_stall, out_valid && !skid_valid)

endmodule
`default_nettype wire
